FILE: src/uda_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the ungapped diagonal alignment block.
// No dependencies; every other file takes names from here by scope.
package uda_pkg;

  // Largest matrix side and the index widths that follow from it
  localparam int MAX_WIDTH  = 64;
  localparam int IDX_W      = $clog2(MAX_WIDTH);
  localparam int CNT_W      = IDX_W + 1;

  // Configuration port shape
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALIGN_MODE = 2'd0,
    CFG_ROWS       = 2'd1,
    CFG_COLS       = 2'd2
  } cfg_idx_t;

  // Alignment mode codes
  localparam logic MODE_LOCAL  = 1'b0;
  localparam logic MODE_GLOBAL = 1'b1;

  // Per-cell control carried from the intake stage to the update stage
  typedef struct packed {
    idx_t row;
    idx_t col;
    logic at_edge;      // row 0 or column 0
    logic global_cand;  // last row or last column of the matrix
    logic last;         // final cell of the matrix
  } cell_ctl_t;

  // Map a raw count register onto 1..MAX_WIDTH
  function automatic cnt_t clamp_count(input logic [CFG_DATA_W-1:0] v);
    cnt_t res;
    if (v == '0) begin
      res = cnt_t'(1);
    end else if (v > CFG_DATA_W'(MAX_WIDTH)) begin
      res = cnt_t'(MAX_WIDTH);
    end else begin
      res = cnt_t'(v);
    end
    return res;
  endfunction

endpackage

FILE: src/uda_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the score cell stream and the result stream.
// Depends on uda_pkg for index widths.

interface uda_in_if #(parameter int SCORE_BITS = 20);
  logic                         valid;
  logic                         ready;
  logic signed [SCORE_BITS-1:0] cell_score;

  modport source (output valid, output cell_score, input ready);
  modport sink   (input valid, input cell_score, output ready);
endinterface

interface uda_out_if #(parameter int SUM_BITS = 28);
  logic                         valid;
  logic                         ready;
  logic signed [SUM_BITS-1:0]   best_score;
  logic [uda_pkg::CNT_W-1:0]    start_row;
  logic [uda_pkg::CNT_W-1:0]    start_col;
  logic [uda_pkg::IDX_W-1:0]    end_row;
  logic [uda_pkg::IDX_W-1:0]    end_col;
  logic [uda_pkg::CNT_W-1:0]    overlap_length;

  modport source (output valid, output best_score, output start_row, output start_col,
                  output end_row, output end_col, output overlap_length, input ready);
  modport sink   (input valid, input best_score, input start_row, input start_col,
                  input end_row, input end_col, input overlap_length, output ready);
endinterface

FILE: src/ungapped_diagonal_alignment.sv
`timescale 1ns / 1ps
// Top level of the ungapped diagonal alignment block: row buffer memory and update stage.
// Depends on uda_pkg and the channel interfaces in uda_if.sv.

// Takes a score matrix in row-major order, one signed cell per request, and builds the
// diagonal sums with a one-row buffer memory (read at intake, written back by the update
// stage, with a bypass for a read of the entry being written). It accepts one cell every
// clock cycle while not stalled; the rate is set by the single read-modify-write of the
// row buffer per column. Once the final cell leaves the update stage the result is loaded
// into an output register and is held there until taken; intake stalls only when the
// final cell of the next matrix reaches the update stage while that result is still
// untaken. A configuration write restarts the matrix scan and must be issued with the
// block idle.
// The row buffer needs no clearing after reset: row 0 fills every entry before use.
module ungapped_diagonal_alignment #(
  parameter int SCORE_BITS = 20,
  parameter int SUM_BITS   = 28
) (
  input  logic                            clk,
  input  logic                            rst_n,
  uda_in_if.sink                          in_req,
  uda_out_if.source                       out_res,
  input  logic                            cfg_we,
  input  logic [uda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uda_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int EXT_W = ((SCORE_BITS > SUM_BITS) ? SCORE_BITS : SUM_BITS) + 1;
  localparam int ENT_W = SUM_BITS + uda_pkg::CNT_W;
  localparam logic signed [EXT_W-1:0] SAT_HI =
    {{(EXT_W-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers
  logic                          mode_r;
  logic [uda_pkg::CFG_DATA_W-1:0] rows_r;
  logic [uda_pkg::CFG_DATA_W-1:0] cols_r;
  logic                          restart;
  uda_pkg::cnt_t                 rows_use;
  uda_pkg::cnt_t                 cols_use;

  // Scan counters
  uda_pkg::idx_t row_cnt_r, row_cnt_nxt;
  uda_pkg::idx_t col_cnt_r, col_cnt_nxt;
  logic          row_last, col_last;

  // Update stage
  logic                         s1_valid_r;
  uda_pkg::cell_ctl_t           s1_r;
  logic signed [SCORE_BITS-1:0] s1_score_r;
  logic [ENT_W-1:0]             rd_r;
  logic signed [SUM_BITS-1:0]   held_sum_r;
  uda_pkg::cnt_t                held_start_r;
  logic                         in_fire, s1_adv, s1_fire;

  // Row buffer
  logic [ENT_W-1:0] row_mem [uda_pkg::MAX_WIDTH];
  logic [ENT_W-1:0] wr_data;

  // Sum datapath
  logic signed [EXT_W-1:0]    score_ext, held_ext, raw_sum;
  logic signed [SUM_BITS-1:0] sat_sum;
  logic signed [SUM_BITS-1:0] sum_nxt;
  uda_pkg::cnt_t              start_nxt;
  logic                       take;

  // Best cell tracking
  logic                       best_seen_r;
  logic signed [SUM_BITS-1:0] best_sum_r;
  uda_pkg::idx_t              best_row_r, best_col_r;
  uda_pkg::cnt_t              best_start_r;

  // Output register
  logic                       out_valid_r;
  logic signed [SUM_BITS-1:0] out_sum_r;
  uda_pkg::cnt_t              out_start_r;
  uda_pkg::idx_t              out_row_r, out_col_r;
  logic signed [uda_pkg::CNT_W+1:0] scol_w, len_w;

  // Decode configuration writes; any known register restarts the scan
  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        uda_pkg::CFG_ALIGN_MODE,
        uda_pkg::CFG_ROWS,
        uda_pkg::CFG_COLS: restart = 1'b1;
        default:           restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= uda_pkg::MODE_LOCAL;
      rows_r <= uda_pkg::CFG_DATA_W'(uda_pkg::MAX_WIDTH);
      cols_r <= uda_pkg::CFG_DATA_W'(uda_pkg::MAX_WIDTH);
    end else if (cfg_we) begin
      case (cfg_index)
        uda_pkg::CFG_ALIGN_MODE: mode_r <= cfg_data[0];
        uda_pkg::CFG_ROWS:       rows_r <= cfg_data;
        uda_pkg::CFG_COLS:       cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows_use = uda_pkg::clamp_count(rows_r);
  assign cols_use = uda_pkg::clamp_count(cols_r);

  // Handshake: stall the update stage only on a final cell facing a full output
  assign s1_adv        = !s1_r.last || !out_valid_r || out_res.ready;
  assign s1_fire       = s1_valid_r && s1_adv;
  assign in_req.ready  = !s1_valid_r || s1_adv;
  assign in_fire       = in_req.valid && in_req.ready;

  // Advance the row and column counters
  assign col_last = ({1'b0, col_cnt_r} + uda_pkg::cnt_t'(1)) >= cols_use;
  assign row_last = ({1'b0, row_cnt_r} + uda_pkg::cnt_t'(1)) >= rows_use;

  always_comb begin
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    if (col_last) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = row_last ? '0 : row_cnt_r + uda_pkg::idx_t'(1);
    end else begin
      col_cnt_nxt = col_cnt_r + uda_pkg::idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (in_fire) begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  // Intake: capture the cell and read the buffer entry of its column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_score_r         <= in_req.cell_score;
      s1_r.row           <= row_cnt_r;
      s1_r.col           <= col_cnt_r;
      s1_r.at_edge       <= (row_cnt_r == '0) || (col_cnt_r == '0);
      s1_r.global_cand   <= row_last || col_last;
      s1_r.last          <= row_last && col_last;
      if (s1_fire && (s1_r.col == col_cnt_r)) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= row_mem[col_cnt_r];
      end
    end
  end

  // Diagonal sum with saturation
  assign score_ext = {{(EXT_W-SCORE_BITS){s1_score_r[SCORE_BITS-1]}}, s1_score_r};
  assign held_ext  = s1_r.at_edge ? '0
                                  : {{(EXT_W-SUM_BITS){held_sum_r[SUM_BITS-1]}}, held_sum_r};
  assign raw_sum   = held_ext + score_ext;

  always_comb begin
    if (raw_sum > SAT_HI) begin
      sat_sum = SAT_HI[SUM_BITS-1:0];
    end else if (raw_sum < SAT_LO) begin
      sat_sum = SAT_LO[SUM_BITS-1:0];
    end else begin
      sat_sum = raw_sum[SUM_BITS-1:0];
    end
  end

  // Clamp and pick the start row by mode
  always_comb begin
    sum_nxt   = sat_sum;
    start_nxt = {1'b0, s1_r.row};
    if (mode_r == uda_pkg::MODE_LOCAL) begin
      if (s1_r.at_edge) begin
        sum_nxt = sat_sum[SUM_BITS-1] ? '0 : sat_sum;
      end else if (!sat_sum[SUM_BITS-1] && (sat_sum != '0)) begin
        start_nxt = held_start_r;
      end else begin
        sum_nxt   = '0;
        start_nxt = {1'b0, s1_r.row} + uda_pkg::cnt_t'(1);
      end
    end else begin
      start_nxt = (s1_r.row < s1_r.col) ? '0 : {1'b0, s1_r.row - s1_r.col};
    end
  end

  assign take = ((mode_r == uda_pkg::MODE_LOCAL) || s1_r.global_cand) &&
                (!best_seen_r || (sum_nxt >= best_sum_r));

  assign wr_data = {sum_nxt, start_nxt};

  // Write back the row buffer and hold the old entry as the next diagonal
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      row_mem[s1_r.col] <= wr_data;
      held_sum_r        <= rd_r[ENT_W-1:uda_pkg::CNT_W];
      held_start_r      <= rd_r[uda_pkg::CNT_W-1:0];
    end
  end

  // Track the best cell; clear after the final cell or on restart
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      best_seen_r  <= 1'b0;
      best_sum_r   <= '0;
      best_row_r   <= '0;
      best_col_r   <= '0;
      best_start_r <= '0;
    end else if (s1_fire) begin
      if (s1_r.last) begin
        best_seen_r  <= 1'b0;
        best_sum_r   <= '0;
        best_row_r   <= '0;
        best_col_r   <= '0;
        best_start_r <= '0;
      end else if (take) begin
        best_seen_r  <= 1'b1;
        best_sum_r   <= sum_nxt;
        best_row_r   <= s1_r.row;
        best_col_r   <= s1_r.col;
        best_start_r <= start_nxt;
      end
    end
  end

  // Load the result register on the final cell; drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_r.last) begin
      if (take) begin
        out_sum_r   <= sum_nxt;
        out_start_r <= start_nxt;
        out_row_r   <= s1_r.row;
        out_col_r   <= s1_r.col;
      end else begin
        out_sum_r   <= best_sum_r;
        out_start_r <= best_start_r;
        out_row_r   <= best_row_r;
        out_col_r   <= best_col_r;
      end
    end
  end

  // Derive start column and length from the held result
  assign scol_w = $signed({3'b000, out_col_r}) - $signed({3'b000, out_row_r})
                + $signed({2'b00, out_start_r});
  assign len_w  = $signed({3'b000, out_row_r}) - $signed({2'b00, out_start_r})
                + $signed((uda_pkg::CNT_W+2)'(1));

  assign out_res.valid          = out_valid_r;
  assign out_res.best_score     = out_sum_r;
  assign out_res.start_row      = out_start_r;
  assign out_res.end_row        = out_row_r;
  assign out_res.end_col        = out_col_r;
  assign out_res.start_col      = scol_w[uda_pkg::CNT_W+1] ? '0 : scol_w[uda_pkg::CNT_W-1:0];
  assign out_res.overlap_length = len_w[uda_pkg::CNT_W+1] ? '0 : len_w[uda_pkg::CNT_W-1:0];

endmodule

FILE: src/uda_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the ungapped diagonal alignment block, bound to the top level.
// Depends on uda_pkg for field widths.
module uda_port_checker #(
  parameter int SUM_BITS = 28
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SUM_BITS-1:0]    best_score,
  input logic [uda_pkg::CNT_W-1:0]     start_row,
  input logic [uda_pkg::IDX_W-1:0]     end_row,
  input logic [uda_pkg::CNT_W-1:0]     overlap_length
);

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(best_score) && $stable(end_row) &&
                                $stable(start_row))
    else $error("result payload changed while stalled");

  // Intake stalls only behind an untaken result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("cell intake stalled without a pending result");

  // Start row lies at most one past the end row, length within the matrix
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (start_row <= ({1'b0, end_row} + uda_pkg::cnt_t'(1))) &&
                  (overlap_length <= uda_pkg::cnt_t'(uda_pkg::MAX_WIDTH)))
    else $error("result span out of range");

endmodule

bind ungapped_diagonal_alignment uda_port_checker #(.SUM_BITS(SUM_BITS)) u_uda_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_req.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .best_score     (out_res.best_score),
  .start_row      (out_res.start_row),
  .end_row        (out_res.end_row),
  .overlap_length (out_res.overlap_length)
);

FILE: sim/uda_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ungapped diagonal alignment block: predicts each alignment result
// from the observed configuration writes and accepted score cells, then compares results.
// Depends on uda_pkg for index widths, register indexes and mode codes.
module uda_checker #(
  parameter int SCORE_BITS = 20,
  parameter int SUM_BITS   = 28
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [uda_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uda_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [SCORE_BITS-1:0]      in_score,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [SUM_BITS-1:0]        out_best_score,
  input  logic [uda_pkg::CNT_W-1:0]         out_start_row,
  input  logic [uda_pkg::CNT_W-1:0]         out_start_col,
  input  logic [uda_pkg::IDX_W-1:0]         out_end_row,
  input  logic [uda_pkg::IDX_W-1:0]         out_end_col,
  input  logic [uda_pkg::CNT_W-1:0]         out_overlap_length,
  output int                                fail_count,
  output int                                pending_results,
  output int                                cells_seen,
  output int                                results_seen
);

  localparam longint SUM_MAX = (longint'(1) << (SUM_BITS - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic signed [SUM_BITS-1:0]    best_score;
    logic [uda_pkg::CNT_W-1:0]     start_row;
    logic [uda_pkg::CNT_W-1:0]     start_col;
    logic [uda_pkg::IDX_W-1:0]     end_row;
    logic [uda_pkg::IDX_W-1:0]     end_col;
    logic [uda_pkg::CNT_W-1:0]     overlap_length;
  } align_result_t;

  // Shadow registers
  logic                           mode_reg;
  logic [uda_pkg::CFG_DATA_W-1:0] rows_reg;
  logic [uda_pkg::CFG_DATA_W-1:0] cols_reg;

  // Previous-row diagonal sums and their start rows
  longint diag_sum   [uda_pkg::MAX_WIDTH];
  int     diag_start [uda_pkg::MAX_WIDTH];

  // Scan position, diagonal predecessor and best cell so far
  int     cell_row;
  int     cell_col;
  longint carry_sum;
  int     carry_start;
  bit     have_best;
  longint best_sum;
  int     best_row;
  int     best_col;
  int     best_start;

  align_result_t result_q [$];

  function automatic longint clip_sum(input longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  // Register value to matrix side: zero reads as one, above the maximum as the maximum
  function automatic int side_len(input logic [uda_pkg::CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (v > uda_pkg::CFG_DATA_W'(uda_pkg::MAX_WIDTH)) return uda_pkg::MAX_WIDTH;
    return int'(v);
  endfunction

  function automatic void restart_scan();
    cell_row    = 0;
    cell_col    = 0;
    carry_sum   = 0;
    carry_start = 0;
    have_best   = 1'b0;
    best_sum    = 0;
    best_row    = 0;
    best_col    = 0;
    best_start  = 0;
  endfunction

  // Advance the scan by one cell; returns 1 with the result after the final cell
  function automatic bit score_cell(input longint sc, output align_result_t res);
    int     rows_n;
    int     cols_n;
    int     i;
    int     j;
    int     start;
    int     old_start;
    int     scol;
    int     len;
    longint sum;
    longint old_sum;
    bit     at_border;
    bit     cand;
    rows_n    = side_len(rows_reg);
    cols_n    = side_len(cols_reg);
    i         = cell_row;
    j         = cell_col;
    at_border = (i == 0) || (j == 0);
    old_sum   = diag_sum[j];
    old_start = diag_start[j];
    res       = '0;

    if (mode_reg == uda_pkg::MODE_LOCAL) begin
      // Clamp at zero; a zero interior sum is an empty match starting past the cell
      if (at_border) begin
        sum = clip_sum(sc);
        if (sum < 0) sum = 0;
        start = i;
      end else begin
        sum = clip_sum(carry_sum + sc);
        if (sum > 0) begin
          start = carry_start;
        end else begin
          sum   = 0;
          start = i + 1;
        end
      end
      cand = 1'b1;
    end else begin
      // Unclamped; only last row and last column compete
      sum   = at_border ? clip_sum(sc) : clip_sum(carry_sum + sc);
      start = i - ((i < j) ? i : j);
      cand  = (i >= rows_n - 1) || (j >= cols_n - 1);
    end

    diag_sum[j]   = sum;
    diag_start[j] = start;
    carry_sum     = old_sum;
    carry_start   = old_start;

    // Ties go to the later cell
    if (cand && (!have_best || sum >= best_sum)) begin
      have_best  = 1'b1;
      best_sum   = sum;
      best_row   = i;
      best_col   = j;
      best_start = start;
    end

    if (j + 1 < cols_n) begin
      cell_col = j + 1;
      return 1'b0;
    end
    cell_col = 0;
    if (i + 1 < rows_n) begin
      cell_row = i + 1;
      return 1'b0;
    end

    scol = best_col - best_row + best_start;
    len  = best_row - best_start + 1;
    res.best_score     = SUM_BITS'(best_sum);
    res.start_row      = uda_pkg::CNT_W'(best_start);
    res.start_col      = uda_pkg::CNT_W'((scol < 0) ? 0 : scol);
    res.end_row        = uda_pkg::IDX_W'(best_row);
    res.end_col        = uda_pkg::IDX_W'(best_col);
    res.overlap_length = uda_pkg::CNT_W'((len < 0) ? 0 : len);
    restart_scan();
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    align_result_t got;
    align_result_t want;
    bit            bad;
    if (!rst_n) begin
      mode_reg = uda_pkg::MODE_LOCAL;
      rows_reg = uda_pkg::CFG_DATA_W'(uda_pkg::MAX_WIDTH);
      cols_reg = uda_pkg::CFG_DATA_W'(uda_pkg::MAX_WIDTH);
      for (int k = 0; k < uda_pkg::MAX_WIDTH; k++) begin
        diag_sum[k]   = 0;
        diag_start[k] = 0;
      end
      restart_scan();
      result_q.delete();
      pending_results = 0;
      fail_count      = 0;
      cells_seen      = 0;
      results_seen    = 0;
    end else begin
      // Compare an accepted result with the oldest expectation
      if (out_valid && out_ready) begin
        got.best_score     = out_best_score;
        got.start_row      = out_start_row;
        got.start_col      = out_start_col;
        got.end_row        = out_end_row;
        got.end_col        = out_end_col;
        got.overlap_length = out_overlap_length;
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result score %0d end (%0d,%0d) at %0t",
                     got.best_score, got.end_row, got.end_col, $realtime);
        end else begin
          want = result_q.pop_front();
          pending_results--;
          results_seen++;
          bad = (got.best_score !== want.best_score) ||
                (got.start_row !== want.start_row) ||
                (got.start_col !== want.start_col) ||
                (got.end_row !== want.end_row) ||
                (got.end_col !== want.end_col) ||
                (got.overlap_length !== want.overlap_length);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: result %0d at %0t", results_seen, $realtime);
              $display("       expected score %0d start (%0d,%0d) end (%0d,%0d) len %0d",
                       want.best_score, want.start_row, want.start_col,
                       want.end_row, want.end_col, want.overlap_length);
              $display("       got score %0d start (%0d,%0d) end (%0d,%0d) len %0d",
                       got.best_score, got.start_row, got.start_col, got.end_row,
                       got.end_col, got.overlap_length);
            end
          end
        end
      end

      // Track register writes; any write to a known register restarts the scan
      if (cfg_we) begin
        case (cfg_index)
          uda_pkg::CFG_ALIGN_MODE: begin
            mode_reg = cfg_data[0];
            restart_scan();
          end
          uda_pkg::CFG_ROWS: begin
            rows_reg = cfg_data;
            restart_scan();
          end
          uda_pkg::CFG_COLS: begin
            cols_reg = cfg_data;
            restart_scan();
          end
          default: ;
        endcase
      end else if (in_valid && in_ready) begin
        cells_seen++;
        if (score_cell(longint'(in_score), want)) begin
          result_q.push_back(want);
          pending_results++;
        end
      end
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the ungapped diagonal alignment block: clock, reset, score cell
// stimulus, result-side stalls, watchdog and verdict. Depends on uda_pkg, uda_if.sv
// and uda_checker.sv.
module tb;

  localparam int SCORE_BITS   = 20;
  localparam int SUM_BITS     = 28;
  localparam int RANDOM_CELLS = 1950;
  localparam int IDLE_LIMIT   = 1000;

  typedef logic signed [SCORE_BITS-1:0] score_t;

  localparam score_t SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam score_t SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [uda_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [uda_pkg::CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending_results;
  int cells_seen;
  int results_seen;

  bit in_calm;
  bit out_calm;

  uda_in_if  #(.SCORE_BITS(SCORE_BITS)) in_ch  ();
  uda_out_if #(.SUM_BITS(SUM_BITS))     out_ch ();

  ungapped_diagonal_alignment #(
    .SCORE_BITS(SCORE_BITS),
    .SUM_BITS  (SUM_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_ch),
    .out_res  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  uda_checker #(
    .SCORE_BITS(SCORE_BITS),
    .SUM_BITS  (SUM_BITS)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_score          (in_ch.cell_score),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_best_score    (out_ch.best_score),
    .out_start_row     (out_ch.start_row),
    .out_start_col     (out_ch.start_col),
    .out_end_row       (out_ch.end_row),
    .out_end_col       (out_ch.end_col),
    .out_overlap_length(out_ch.overlap_length),
    .fail_count        (fail_count),
    .pending_results   (pending_results),
    .cells_seen        (cells_seen),
    .results_seen      (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Matrix side: mostly small, rarely up to the maximum
  function automatic int pick_side();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 92) return $urandom_range(9, 20);
    return $urandom_range(21, uda_pkg::MAX_WIDTH);
  endfunction

  // Register value for a side, sometimes out of range with the same effect
  function automatic logic [uda_pkg::CFG_DATA_W-1:0] side_to_reg(input int side);
    if (side == 1 && $urandom_range(0, 7) == 0) return '0;
    if (side == uda_pkg::MAX_WIDTH && $urandom_range(0, 1) == 0)
      return uda_pkg::CFG_DATA_W'($urandom_range(uda_pkg::MAX_WIDTH + 1,
                                                 (1 << uda_pkg::CFG_DATA_W) - 1));
    return uda_pkg::CFG_DATA_W'(side);
  endfunction

  function automatic score_t cell_value(input int flavor);
    case (flavor)
      0: return score_t'($urandom());
      1: return score_t'(int'($urandom_range(0, 4000)) - 2000);
      2: begin
        case ($urandom_range(0, 4))
          0: return SCORE_MAX;
          1: return SCORE_MIN;
          2: return score_t'(0);
          3: return score_t'(1);
          default: return score_t'(-1);
        endcase
      end
      default: begin
        // Long positive runs broken by an occasional deep drop
        if ($urandom_range(0, 5) == 0) return score_t'(-int'($urandom_range(1000, 524288)));
        return score_t'(int'($urandom_range(0, 3000)));
      end
    endcase
  endfunction

  // Drive one request and hold it until accepted; returns at a falling edge
  task automatic send_cell(input score_t v);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cell_score <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all three registers on consecutive cycles
  task automatic set_config(input logic mode,
                            input logic [uda_pkg::CFG_DATA_W-1:0] rows_val,
                            input logic [uda_pkg::CFG_DATA_W-1:0] cols_val);
    cfg_we    <= 1'b1;
    cfg_index <= uda_pkg::CFG_ALIGN_MODE;
    cfg_data  <= uda_pkg::CFG_DATA_W'(mode);
    @(negedge clk);
    cfg_index <= uda_pkg::CFG_ROWS;
    cfg_data  <= rows_val;
    @(negedge clk);
    cfg_index <= uda_pkg::CFG_COLS;
    cfg_data  <= cols_val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drop valid, drain every expected result and let the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_list(input score_t cells []);
    foreach (cells[k]) send_cell(cells[k]);
  endtask

  // Result side: ready with random stalls
  initial begin : result_sink
    int stall;
    stall        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap(out_calm);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("ERROR: no request accepted for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int     shape_rows [5];
    int     shape_cols [5];
    int     random_cells;
    int     phase;
    int     rows;
    int     cols;
    int     mats;
    int     flavor;
    logic   mode;
    score_t cells [];

    shape_rows = '{1, uda_pkg::MAX_WIDTH, 1, uda_pkg::MAX_WIDTH, 2};
    shape_cols = '{1, 1, uda_pkg::MAX_WIDTH, 3, uda_pkg::MAX_WIDTH};
    random_cells = 0;
    in_calm  = 1'b0;
    out_calm = 1'b0;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = uda_pkg::CFG_ALIGN_MODE;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.cell_score = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Local, all negative: every sum clamps to zero, the last cell wins the tie
    // and is an empty match starting past itself
    set_config(uda_pkg::MODE_LOCAL, 7'd3, 7'd3);
    cells = '{score_t'(-1), SCORE_MIN, score_t'(-5), score_t'(-2), score_t'(-3),
              SCORE_MIN, score_t'(-9), score_t'(-1), SCORE_MIN};
    send_list(cells);
    drain();

    // Local, field extremes: the diagonal run inherits its edge start
    set_config(uda_pkg::MODE_LOCAL, 7'd2, 7'd2);
    cells = '{SCORE_MAX, SCORE_MIN, SCORE_MIN, SCORE_MAX};
    send_list(cells);
    drain();

    // Global, last row and last column compete, start at the diagonal edge
    set_config(uda_pkg::MODE_GLOBAL, 7'd3, 7'd2);
    cells = '{score_t'(100), score_t'(-200), score_t'(-300), score_t'(50),
              score_t'(400), score_t'(-1)};
    send_list(cells);
    drain();

    // Global, zero row count reads as one row; negative tie goes to the later cell
    set_config(uda_pkg::MODE_GLOBAL, 7'd0, 7'd3);
    cells = '{score_t'(-7), score_t'(-7), score_t'(-9)};
    send_list(cells);
    drain();

    // Random phases: fixed extreme shapes first, then mostly small matrices
    phase = 0;
    while (random_cells < RANDOM_CELLS) begin
      if (phase < 5) begin
        rows = shape_rows[phase];
        cols = shape_cols[phase];
        mode = phase[0];
      end else begin
        rows = pick_side();
        cols = (rows > 20) ? $urandom_range(1, 4) : pick_side();
        mode = $urandom_range(0, 1);
      end
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      set_config(mode, side_to_reg(rows), side_to_reg(cols));
      mats = (rows * cols > 100) ? 1 : $urandom_range(1, 3);
      repeat (mats) begin
        flavor = $urandom_range(0, 3);
        repeat (rows * cols) begin
          send_cell(cell_value(flavor));
          random_cells++;
        end
      end
      drain();
      phase++;
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d alignment results from %0d score cells in local and global mode,",
             results_seen, cells_seen);
    $display("matrix sides 1 to %0d including out-of-range counts, with stalls on both sides.",
             uda_pkg::MAX_WIDTH);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
